// File: sv/mpbc_pkg.sv
// Shared types, register indexes and small helper functions for the masked
// pixel to BGRA converter. No dependencies.
package mpbc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned NUM_CHAN    = 3;

  // Channel slots, in output order.
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BITS       = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD        = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH      = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MSB_FIRST  = 4'd7;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_LOAD,
    SU_SCAN,
    SU_DONE
  } setup_state_t;

  typedef enum logic [1:0] {
    CM_ZERO,
    CM_TOP,
    CM_UNIT,
    CM_SCALE
  } chan_mode_t;

  // Frame geometry seen by the byte front end.
  typedef struct packed {
    logic [2:0]  bpp;
    logic [18:0] stride;
    logic [15:0] width;
    logic [16:0] rows;
    logic        msb_first;
  } frame_cfg_t;

  // Per-channel extraction setup.
  typedef struct packed {
    logic [31:0] mask;
    logic [5:0]  w;
    logic [4:0]  shift;
    logic [4:0]  top_shift;
    logic [30:0] recip;
  } chan_cfg_t;

  // One assembled pixel on its way to the channel unit.
  typedef struct packed {
    logic [31:0] pixel;
    logic        has_alpha;
    logic        row_end;
    logic        frame_end;
  } pixel_t;

  function automatic logic [2:0] pixel_byte_count(input logic [5:0] bits);
    logic [6:0] sum;
    begin
      sum = {1'b0, bits} + 7'd7;
      if (bits == 6'd0) begin
        pixel_byte_count = 3'd1;
      end else if (bits > 6'd32) begin
        pixel_byte_count = 3'd4;
      end else begin
        pixel_byte_count = sum[5:3];
      end
    end
  endfunction

  // floor(2^32 / (2^w - 1)) for the widths that need scaling.
  function automatic logic [30:0] recip_of(input logic [5:0] w);
    begin
      case (w)
        6'd2:    recip_of = 31'd1431655765;
        6'd3:    recip_of = 31'd613566756;
        6'd4:    recip_of = 31'd286331153;
        6'd5:    recip_of = 31'd138547332;
        6'd6:    recip_of = 31'd68174084;
        6'd7:    recip_of = 31'd33818640;
        default: recip_of = 31'd0;
      endcase
    end
  endfunction

  function automatic chan_mode_t mode_of(input logic [5:0] w);
    begin
      if (w == 6'd0) begin
        mode_of = CM_ZERO;
      end else if (w >= 6'd8) begin
        mode_of = CM_TOP;
      end else if (w == 6'd1) begin
        mode_of = CM_UNIT;
      end else begin
        mode_of = CM_SCALE;
      end
    end
  endfunction

endpackage

// File: sv/mpbc_setup.sv
// Configuration registers and the setup sequencer that derives stride,
// channel shifts, widths and reciprocals. Uses mpbc_pkg.
module mpbc_setup (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data,
  output logic                               busy,
  output mpbc_pkg::frame_cfg_t               fcfg,
  output mpbc_pkg::chan_cfg_t [mpbc_pkg::NUM_CHAN-1:0] ccfg
);

  mpbc_pkg::setup_state_t state, state_next;

  logic [mpbc_pkg::NUM_CHAN-1:0][31:0] masks;
  logic [5:0]  bits;
  logic [7:0]  pad;
  logic [15:0] width;
  logic [15:0] height;
  logic        msb_first;

  logic        cfg_write;
  logic        load_en, scan_en, done_en;

  logic [4:0]  bit_idx;
  logic [20:0] bits_total;
  logic [20:0] bits_shift;
  logic [7:0]  rem;
  logic [2:0]  bpp;
  logic [18:0] stride;
  logic [mpbc_pkg::NUM_CHAN-1:0][5:0] w_cnt;
  logic [mpbc_pkg::NUM_CHAN-1:0][4:0] shift;
  logic [mpbc_pkg::NUM_CHAN-1:0][4:0] top_shift;
  logic [mpbc_pkg::NUM_CHAN-1:0][30:0] recip;

  logic [2:0]  bpp_c;
  logic [17:0] width_x_bpp;
  logic [8:0]  rem_sh;
  logic [21:0] padded;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks[mpbc_pkg::CH_RED]   <= 32'h00FF_0000;
      masks[mpbc_pkg::CH_GREEN] <= 32'h0000_FF00;
      masks[mpbc_pkg::CH_BLUE]  <= 32'h0000_00FF;
      bits      <= 6'd32;
      pad       <= 8'd32;
      width     <= 16'd1;
      height    <= 16'd1;
      msb_first <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        mpbc_pkg::REG_RED_MASK:   masks[mpbc_pkg::CH_RED]   <= cfg_data;
        mpbc_pkg::REG_GREEN_MASK: masks[mpbc_pkg::CH_GREEN] <= cfg_data;
        mpbc_pkg::REG_BLUE_MASK:  masks[mpbc_pkg::CH_BLUE]  <= cfg_data;
        mpbc_pkg::REG_BITS:       bits      <= cfg_data[5:0];
        mpbc_pkg::REG_PAD:        pad       <= cfg_data[7:0];
        mpbc_pkg::REG_WIDTH:      width     <= cfg_data[15:0];
        mpbc_pkg::REG_HEIGHT:     height    <= cfg_data[15:0];
        mpbc_pkg::REG_MSB_FIRST:  msb_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Any write restarts the derivation; reset runs it once for the defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpbc_pkg::SU_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mpbc_pkg::SU_IDLE: state_next = mpbc_pkg::SU_IDLE;
      mpbc_pkg::SU_LOAD: state_next = mpbc_pkg::SU_SCAN;
      mpbc_pkg::SU_SCAN: begin
        if (bit_idx == 5'd31) begin
          state_next = mpbc_pkg::SU_DONE;
        end
      end
      mpbc_pkg::SU_DONE: state_next = mpbc_pkg::SU_IDLE;
      default:           state_next = mpbc_pkg::SU_LOAD;
    endcase
    if (cfg_write) begin
      state_next = mpbc_pkg::SU_LOAD;
    end
  end

  always_comb begin
    busy    = (state != mpbc_pkg::SU_IDLE);
    load_en = (state == mpbc_pkg::SU_LOAD);
    scan_en = (state == mpbc_pkg::SU_SCAN);
    done_en = (state == mpbc_pkg::SU_DONE);
  end

  always_comb begin
    bpp_c = mpbc_pkg::pixel_byte_count(bits);
    case (bpp_c)
      3'd1:    width_x_bpp = {2'b0, width};
      3'd2:    width_x_bpp = {1'b0, width, 1'b0};
      3'd3:    width_x_bpp = {1'b0, width, 1'b0} + {2'b0, width};
      default: width_x_bpp = {width, 2'b0};
    endcase
    rem_sh = {rem, bits_shift[20]};
    if (rem == 8'd0 || pad == 8'd0) begin
      padded = {1'b0, bits_total};
    end else begin
      padded = {1'b0, bits_total} + {14'b0, pad} - {14'b0, rem};
    end
  end

  // Restoring remainder over the 21 row bits, mask bit walk over all 32 mask bits.
  always_ff @(posedge clk) begin
    if (load_en) begin
      bit_idx    <= 5'd0;
      bpp        <= bpp_c;
      bits_total <= {width_x_bpp, 3'b0};
      bits_shift <= {width_x_bpp, 3'b0};
      rem        <= 8'd0;
      for (int ch = 0; ch < mpbc_pkg::NUM_CHAN; ch++) begin
        w_cnt[ch] <= 6'd0;
        shift[ch] <= 5'd0;
      end
    end else if (scan_en) begin
      bit_idx <= bit_idx + 5'd1;
      if (bit_idx < 5'd21) begin
        bits_shift <= {bits_shift[19:0], 1'b0};
        if (rem_sh >= {1'b0, pad}) begin
          rem <= 8'(rem_sh - {1'b0, pad});
        end else begin
          rem <= rem_sh[7:0];
        end
      end
      for (int ch = 0; ch < mpbc_pkg::NUM_CHAN; ch++) begin
        if (masks[ch][bit_idx]) begin
          if (w_cnt[ch] == 6'd0) begin
            shift[ch] <= bit_idx;
          end
          w_cnt[ch] <= w_cnt[ch] + 6'd1;
        end
      end
    end else if (done_en) begin
      stride <= padded[21:3];
      for (int ch = 0; ch < mpbc_pkg::NUM_CHAN; ch++) begin
        top_shift[ch] <= 5'({1'b0, shift[ch]} + w_cnt[ch] - 6'd8);
        recip[ch]     <= mpbc_pkg::recip_of(w_cnt[ch]);
      end
    end
  end

  always_comb begin
    fcfg.bpp       = bpp;
    fcfg.stride    = stride;
    fcfg.width     = width;
    fcfg.rows      = {(height == 16'd0), height};
    fcfg.msb_first = msb_first;
    for (int ch = 0; ch < mpbc_pkg::NUM_CHAN; ch++) begin
      ccfg[ch].mask      = masks[ch];
      ccfg[ch].w         = w_cnt[ch];
      ccfg[ch].shift     = shift[ch];
      ccfg[ch].top_shift = top_shift[ch];
      ccfg[ch].recip     = recip[ch];
    end
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (scan_en && bit_idx == 5'd31)
      |=> (state == mpbc_pkg::SU_DONE || state == mpbc_pkg::SU_LOAD))
    else $error("setup scan did not finish after the last mask bit");

endmodule

// File: sv/mpbc_front.sv
// Byte front end: assembles pixels, tracks row and frame position, drops
// padding and pushes finished pixels into the queue. Uses mpbc_pkg.
module mpbc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 busy,
  input  mpbc_pkg::frame_cfg_t fcfg,
  input  logic                 q_full,
  output logic                 push,
  output mpbc_pkg::pixel_t     push_data
);

  logic [31:0] acc, acc_next;
  logic [1:0]  bip, bip_next;
  logic [18:0] bir, bir_next;
  logic [15:0] col, col_next;
  logic [15:0] row, row_next;

  logic        accept, step;
  logic        last_row, in_pix, pix_done, rend, row_wrap;
  logic [31:0] acc_base, acc_asm;

  assign s_tready = !busy && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign step     = accept && (fcfg.width != 16'd0);

  always_comb begin
    last_row = ({1'b0, row} + 17'd1) >= fcfg.rows;
    in_pix   = col < fcfg.width;
    acc_base = (bip == 2'd0) ? 32'd0 : acc;
    if (fcfg.msb_first) begin
      acc_asm = {acc_base[23:0], s_tdata};
    end else begin
      acc_asm = acc_base | ({24'd0, s_tdata} << {bip, 3'b000});
    end
    pix_done = ({1'b0, bip} + 3'd1) >= fcfg.bpp;
    rend     = ({1'b0, col} + 17'd1) == {1'b0, fcfg.width};
    row_wrap = ({1'b0, bir} + 20'd1) >= {1'b0, fcfg.stride};

    acc_next = acc;
    bip_next = bip;
    col_next = col;
    row_next = row;
    if (in_pix) begin
      acc_next = acc_asm;
      if (pix_done) begin
        bip_next = 2'd0;
        col_next = col + 16'd1;
      end else begin
        bip_next = bip + 2'd1;
      end
    end
    // End of stride: drop any partial pixel and move to the next row.
    if (row_wrap) begin
      bir_next = 19'd0;
      col_next = 16'd0;
      bip_next = 2'd0;
      row_next = last_row ? 16'd0 : row + 16'd1;
    end else begin
      bir_next = bir + 19'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
      bip <= 2'd0;
      bir <= 19'd0;
      col <= 16'd0;
      row <= 16'd0;
    end else if (step) begin
      acc <= acc_next;
      bip <= bip_next;
      bir <= bir_next;
      col <= col_next;
      row <= row_next;
    end
  end

  assign push                = step && in_pix && pix_done;
  assign push_data.pixel     = acc_asm;
  assign push_data.has_alpha = (fcfg.bpp >= 3'd4);
  assign push_data.row_end   = rend;
  assign push_data.frame_end = rend && last_row;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !busy)
    else $error("byte accepted while setup still running");

endmodule

// File: sv/mpbc_fifo.sv
// Small register queue between the front end and the channel unit.
// Generic over width and depth; no package dependency.
module mpbc_fifo #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("pixel pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: sv/mpbc_back.sv
// Channel unit: isolates blue, green and red by mask, keeps the top byte or
// scales narrow fields, and drives the output stream. Uses mpbc_pkg.
module mpbc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  mpbc_pkg::pixel_t    q_data,
  output logic                q_pop,
  input  mpbc_pkg::chan_cfg_t [mpbc_pkg::NUM_CHAN-1:0] ccfg,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,   // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha
  output logic                m_tlast,   // row_end
  output logic [1:0]          m_tuser    // [0] has_alpha, [1] frame_end
);

  localparam int unsigned NC = mpbc_pkg::NUM_CHAN;

  logic adv;
  logic v1, v2, v3;

  // Stage 1: masked field, raw*255, top byte, mode.
  logic [NC-1:0][31:0] x1;
  logic [NC-1:0][7:0]  top1;
  mpbc_pkg::chan_mode_t mode1 [NC];
  logic [2:0] flags1;

  // Stage 2: reciprocal estimate of the quotient.
  logic [NC-1:0][31:0] x2;
  logic [NC-1:0][30:0] q2;
  logic [NC-1:0][7:0]  top2;
  mpbc_pkg::chan_mode_t mode2 [NC];
  logic [2:0] flags2;

  logic [NC-1:0][31:0] masked_c, raw_c, top_c;
  logic [NC-1:0][62:0] prod_c;
  logic [NC-1:0][31:0] q0_c, qd_c, r_c, d_c;
  logic [NC-1:0][7:0]  val_c;

  logic [NC-1:0][7:0]  chan_out;
  logic [2:0]          flags3;

  // The whole pipeline holds while the output register is stalled.
  assign adv   = !v3 || m_tready;
  assign q_pop = adv && q_valid;

  always_comb begin
    for (int ch = 0; ch < NC; ch++) begin
      masked_c[ch] = q_data.pixel & ccfg[ch].mask;
      raw_c[ch]    = masked_c[ch] >> ccfg[ch].shift;
      top_c[ch]    = masked_c[ch] >> ccfg[ch].top_shift;
      prod_c[ch]   = {31'd0, x1[ch]} * {32'd0, ccfg[ch].recip};
      q0_c[ch]     = {1'b0, q2[ch]};
      qd_c[ch]     = (q0_c[ch] << ccfg[ch].w[2:0]) - q0_c[ch];
      r_c[ch]      = x2[ch] - qd_c[ch];
      d_c[ch]      = (32'd1 << ccfg[ch].w[2:0]) - 32'd1;
      case (mode2[ch])
        mpbc_pkg::CM_ZERO:  val_c[ch] = 8'd0;
        mpbc_pkg::CM_TOP:   val_c[ch] = top2[ch];
        mpbc_pkg::CM_UNIT:  val_c[ch] = x2[ch][7:0];
        mpbc_pkg::CM_SCALE: val_c[ch] = (r_c[ch] >= d_c[ch]) ? q0_c[ch][7:0] + 8'd1
                                                             : q0_c[ch][7:0];
        default:            val_c[ch] = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NC; ch++) begin
        x1[ch]    <= (raw_c[ch] << 8) - raw_c[ch];
        top1[ch]  <= top_c[ch][7:0];
        mode1[ch] <= mpbc_pkg::mode_of(ccfg[ch].w);
        x2[ch]    <= x1[ch];
        q2[ch]    <= prod_c[ch][62:32];
        top2[ch]  <= top1[ch];
        mode2[ch] <= mode1[ch];
        chan_out[ch] <= val_c[ch];
      end
      flags1 <= {q_data.has_alpha, q_data.row_end, q_data.frame_end};
      flags2 <= flags1;
      flags3 <= flags2;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {(flags3[2] ? 8'hFF : 8'h00),
                     chan_out[mpbc_pkg::CH_RED],
                     chan_out[mpbc_pkg::CH_GREEN],
                     chan_out[mpbc_pkg::CH_BLUE]};
  assign m_tlast  = flags3[1];
  assign m_tuser  = {flags3[0], flags3[2]};

endmodule

// File: sv/masked_pixel_to_bgra_converter.sv
// Masked pixel to BGRA converter. Raw image bytes enter on s_* at one byte
// per cycle while setup is idle and the pixel queue (QUEUE_DEPTH entries)
// has room; intake stalls only during setup or when the output side backs
// up into a full queue. Each complete source pixel leaves on m_* as one
// BGR/BGRA item after the pixel queue, stage 1, stage 2 and the output
// register. After reset and after every configuration write the setup
// sequencer derives stride, channel shifts, widths and reciprocals;
// s_tready stays low meanwhile, but the configuration port takes writes.
// Depends on mpbc_pkg, mpbc_setup, mpbc_front, mpbc_fifo and mpbc_back.
module masked_pixel_to_bgra_converter #(
  parameter int unsigned QUEUE_DEPTH = mpbc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] data_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // [7:0] blue, [15:8] green,
                                                      // [23:16] red, [31:24] alpha
  output logic                             m_tlast,   // row_end
  output logic [1:0]                       m_tuser,   // [0] has_alpha, [1] frame_end
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int unsigned PIX_W = $bits(mpbc_pkg::pixel_t);

  logic                  busy;
  mpbc_pkg::frame_cfg_t  fcfg;
  mpbc_pkg::chan_cfg_t [mpbc_pkg::NUM_CHAN-1:0] ccfg;

  logic                  push, q_full, q_pop, q_valid;
  mpbc_pkg::pixel_t      push_data, q_data;
  logic [PIX_W-1:0]      q_rdata;

  mpbc_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .fcfg      (fcfg),
    .ccfg      (ccfg)
  );

  mpbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .busy      (busy),
    .fcfg      (fcfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mpbc_fifo #(
    .WIDTH (PIX_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  assign q_data = mpbc_pkg::pixel_t'(q_rdata);

  mpbc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .ccfg     (ccfg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
